// ----- src/assert_macros.svh -----
// assertion macros shared by the list engine rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check: property holds at every edge outside reset
`define PLM_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check that a condition implies a property on the next edge
`define PLM_ASSERT_NEXT(lbl, clk, rst_n, cond, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

// ----- src/plm_pkg.sv -----
// types and constants of the positional list engine
// no dependencies
`default_nettype none

package plm_pkg;

	localparam int DATA_W = 32;
	localparam int IDX_W = 7;
	localparam int RESULT_LIMIT = 32;
	localparam logic [DATA_W-1:0] EMPTY_ELEMENT = '1;

	typedef enum logic [2:0] {
		MODE_INSERT  = 3'd0,
		MODE_DELETE  = 3'd1,
		MODE_DUMP    = 3'd2,
		MODE_MOVE    = 3'd3,
		MODE_REVERSE = 3'd4,
		MODE_ROTL    = 3'd5,
		MODE_ROTR    = 3'd6
	} mode_t;

	typedef struct packed {
		logic [2:0]        mode;
		logic signed [31:0] value;
		logic [5:0]        position;
		logic [4:0]        target_position;
	} cmd_t;

	typedef struct packed {
		logic signed [31:0] element;
		logic              is_last;
		logic              list_empty;
	} rsp_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_SHL,
		CELL_SHR
	} cell_op_t;

	typedef struct packed {
		cell_op_t          op;
		logic [IDX_W-1:0]  lo;
		logic [IDX_W-1:0]  hi;
	} cell_ctl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_ROT,
		ST_REV,
		ST_DUMP
	} state_t;

endpackage

`default_nettype wire

// ----- src/plm_stream_if.sv -----
// valid/ready stream interface carrying one payload type
// depends on nothing; payload types come from plm_pkg
`default_nettype none

interface plm_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- src/plm_cell.sv -----
// one entry of the sequence chain: holds a value, takes a neighbor or the head value
// depends on plm_pkg
`default_nettype none

module plm_cell #(
	parameter int IDX = 0
) (
	input  logic                     clk,
	input  plm_pkg::cell_ctl_t       ctl,
	input  logic [plm_pkg::DATA_W-1:0] left,
	input  logic [plm_pkg::DATA_W-1:0] right,
	input  logic [plm_pkg::DATA_W-1:0] head,
	output logic [plm_pkg::DATA_W-1:0] data
);
	import plm_pkg::*;

	localparam logic [IDX_W-1:0] ME = IDX_W'(IDX);

	logic [DATA_W-1:0] data_q, data_d;

	always_comb begin
		data_d = data_q;
		unique case (ctl.op)
			CELL_HOLD: ;
			// range moves one place toward the low end, head lands at hi
			CELL_SHL: begin
				if (ME == ctl.hi) data_d = head;
				else if (ME >= ctl.lo && ME < ctl.hi) data_d = right;
			end
			// range moves one place toward the high end, head lands at lo
			CELL_SHR: begin
				if (ME == ctl.lo) data_d = head;
				else if (ME > ctl.lo && ME <= ctl.hi) data_d = left;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign data = data_q;

endmodule

`default_nettype wire

// ----- src/positional_list_engine_top.sv -----
// top level of the positional list engine: control sequencer and a chain of cells
// depends on plm_pkg, plm_stream_if, plm_cell and assert_macros.svh
//
//  channel | dir | payload                                  | handshake
//  cmd     | in  | mode, value, position, target_position    | valid/ready
//  rsp     | out | element, is_last, list_empty             | valid/ready
//
// insert, delete and move: one shift of the cell chain; ignored commands leave it as is
// dump: one rotation per element, up to RESULT_LIMIT results (one result when empty), paced by the rsp register
// rotate: remainder of value by n (one dividend bit a cycle), then up to n-1 rotations
// reverse: n-1 steps, each rotates a shrinking prefix by one place
// reset clears count, state and the output valid; entries are written before read
// cmd is taken only in idle; rsp stalls hold the dump in place
`default_nettype none
`include "assert_macros.svh"

module positional_list_engine_top #(
	parameter int DEPTH = 32
) (
	input logic         clk,
	input logic         arst_n,
	plm_stream_if.sink   cmd,
	plm_stream_if.source rsp
);
	import plm_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam int AW = $clog2(DEPTH);
	localparam logic [IDX_W-1:0] DEPTH_I = IDX_W'(DEPTH);
	localparam logic [IDX_W-1:0] LIMIT_I = IDX_W'(RESULT_LIMIT);

	state_t            state_q, state_d;
	logic [CW-1:0]     n_q, n_d;
	logic [IDX_W-1:0]  n_x;
	cmd_t              cmd_q;
	logic [IDX_W-1:0]  rem_q, rem_d, rem_t;
	logic [4:0]        bit_q, bit_d;
	logic [IDX_W-1:0]  cnt_q, cnt_d;
	logic              ov_q, ov_d;
	rsp_t              rsp_q, rsp_d;
	logic              acc, out_free, ins_ok;
	logic [IDX_W-1:0]  pos_x, tgt_x;
	cell_ctl_t         ctl;
	logic              use_value;
	logic [IDX_W-1:0]  head_addr;
	logic [DATA_W-1:0] head;
	logic [DATA_W-1:0] cell_q [DEPTH];

	assign n_x      = IDX_W'(n_q);
	assign pos_x    = IDX_W'(cmd.data.position);
	assign tgt_x    = IDX_W'(cmd.data.target_position);
	assign cmd.ready = (state_q == ST_IDLE);
	assign acc      = cmd.valid && cmd.ready;
	assign out_free = !ov_q || rsp.ready;
	assign ins_ok   = (pos_x <= n_x) && (n_x < DEPTH_I);
	assign head     = use_value ? DATA_W'(cmd.data.value) : cell_q[head_addr[AW-1:0]];

	genvar g;
	generate
		for (g = 0; g < DEPTH; g++) begin : g_cell
			logic [DATA_W-1:0] left_v, right_v;
			if (g == 0) begin : g_first
				assign left_v = '0;
			end else begin : g_mid_l
				assign left_v = cell_q[g-1];
			end
			if (g == DEPTH - 1) begin : g_last
				assign right_v = '0;
			end else begin : g_mid_r
				assign right_v = cell_q[g+1];
			end
			plm_cell #(.IDX(g)) u_cell (
				.clk   (clk),
				.ctl   (ctl),
				.left  (left_v),
				.right (right_v),
				.head  (head),
				.data  (cell_q[g])
			);
		end
	endgenerate

	always_comb begin
		state_d   = state_q;
		n_d       = n_q;
		rem_d     = rem_q;
		bit_d     = bit_q;
		cnt_d     = cnt_q;
		ov_d      = ov_q && !rsp.ready;
		rsp_d     = rsp_q;
		ctl       = '{op: CELL_HOLD, lo: '0, hi: '0};
		use_value = 1'b0;
		head_addr = '0;
		rem_t     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (acc) begin
					unique case (mode_t'(cmd.data.mode))
						MODE_INSERT: begin
							if (ins_ok) begin
								ctl       = '{op: CELL_SHR, lo: pos_x, hi: n_x};
								use_value = 1'b1;
								n_d       = n_q + 1'b1;
							end
						end
						MODE_DELETE: begin
							if (pos_x < n_x) begin
								ctl       = '{op: CELL_SHL, lo: pos_x, hi: n_x - 1'b1};
								head_addr = pos_x;
								n_d       = n_q - 1'b1;
							end
						end
						MODE_DUMP: begin
							state_d = ST_DUMP;
							cnt_d   = '0;
						end
						MODE_MOVE: begin
							if (pos_x < n_x && tgt_x < n_x && pos_x != tgt_x) begin
								head_addr = pos_x;
								if (pos_x < tgt_x)
									ctl = '{op: CELL_SHL, lo: pos_x, hi: tgt_x};
								else
									ctl = '{op: CELL_SHR, lo: tgt_x, hi: pos_x};
							end
						end
						MODE_REVERSE: begin
							if (n_x > 1) begin
								state_d = ST_REV;
								cnt_d   = n_x - 1'b1;
							end
						end
						MODE_ROTL, MODE_ROTR: begin
							if (!cmd.data.value[31] && n_x > 1) begin
								state_d = ST_DIV;
								rem_d   = '0;
								bit_d   = 5'd31;
							end
						end
						default: ;
					endcase
				end
			end
			// restoring remainder, one dividend bit per cycle
			ST_DIV: begin
				rem_t = {rem_q[IDX_W-2:0], cmd_q.value[bit_q]};
				if (rem_t >= n_x) rem_t = rem_t - n_x;
				rem_d = rem_t;
				bit_d = bit_q - 1'b1;
				if (bit_q == 5'd0) begin
					if (rem_t == '0) begin
						state_d = ST_IDLE;
					end else begin
						state_d = ST_ROT;
						cnt_d   = (mode_t'(cmd_q.mode) == MODE_ROTL) ? rem_t : n_x - rem_t;
					end
				end
			end
			ST_ROT: begin
				ctl   = '{op: CELL_SHL, lo: '0, hi: n_x - 1'b1};
				cnt_d = cnt_q - 1'b1;
				if (cnt_q == 1) state_d = ST_IDLE;
			end
			// rotating prefixes of shrinking length by one reverses the list
			ST_REV: begin
				ctl   = '{op: CELL_SHL, lo: '0, hi: cnt_q};
				cnt_d = cnt_q - 1'b1;
				if (cnt_q == 1) state_d = ST_IDLE;
			end
			// element 0 goes out, chain rotates; n rotations restore the order
			ST_DUMP: begin
				if (n_x == '0) begin
					if (out_free) begin
						ov_d    = 1'b1;
						rsp_d   = '{element: EMPTY_ELEMENT, is_last: 1'b1, list_empty: 1'b1};
						state_d = ST_IDLE;
					end
				end else if (cnt_q < LIMIT_I) begin
					if (out_free) begin
						ov_d  = 1'b1;
						rsp_d = '{element: cell_q[0],
							is_last: (cnt_q + 1'b1 == n_x) || (cnt_q + 1'b1 == LIMIT_I),
							list_empty: 1'b0};
						ctl   = '{op: CELL_SHL, lo: '0, hi: n_x - 1'b1};
						cnt_d = cnt_q + 1'b1;
						if (cnt_q + 1'b1 == n_x) state_d = ST_IDLE;
					end
				end else begin
					ctl   = '{op: CELL_SHL, lo: '0, hi: n_x - 1'b1};
					cnt_d = cnt_q + 1'b1;
					if (cnt_q + 1'b1 == n_x) state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			n_q     <= '0;
			ov_q    <= 1'b0;
			cnt_q   <= '0;
			bit_q   <= '0;
		end else begin
			state_q <= state_d;
			n_q     <= n_d;
			ov_q    <= ov_d;
			cnt_q   <= cnt_d;
			bit_q   <= bit_d;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) cmd_q <= cmd.data;
		rem_q <= rem_d;
		rsp_q <= rsp_d;
	end

	assign rsp.valid = ov_q;
	assign rsp.data  = rsp_q;

	`PLM_ASSERT(a_empty_is_last, clk, arst_n, rsp.valid && rsp.data.list_empty |-> rsp.data.is_last, "empty dump result not marked last")
	`PLM_ASSERT(a_count_max, clk, arst_n, n_x <= DEPTH_I, "element count above depth")
	`PLM_ASSERT_NEXT(a_insert_grows, clk, arst_n, acc && mode_t'(cmd.data.mode) == MODE_INSERT && ins_ok, n_x == $past(n_x) + 1'b1, "valid insert did not grow count")

endmodule

`default_nettype wire
